// ----- src/ebr_pkg.sv -----
// shared types and constants for the exp-golomb bitstream reader/writer
// no dependencies
package ebr_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CUR_W     = 13;
  localparam logic [CUR_W-1:0] CURSOR_MAX = {CUR_W{1'b1}};
  localparam logic [5:0] MAX_BITS  = 6'd32;
  localparam logic [4:0] MAX_ZEROS = 5'd31;

  localparam logic [3:0] CMD_LOAD   = 4'd0;
  localparam logic [3:0] CMD_REWIND = 4'd1;
  localparam logic [3:0] CMD_READ   = 4'd2;
  localparam logic [3:0] CMD_PEEK   = 4'd3;
  localparam logic [3:0] CMD_SKIP   = 4'd4;
  localparam logic [3:0] CMD_ALIGN  = 4'd5;
  localparam logic [3:0] CMD_UE     = 4'd6;
  localparam logic [3:0] CMD_SE     = 4'd7;
  localparam logic [3:0] CMD_WRITE  = 4'd8;
  localparam logic [3:0] CMD_PAD0   = 4'd9;
  localparam logic [3:0] CMD_PAD1   = 4'd10;

  localparam logic REG_STREAM_LENGTH = 1'b0;
  localparam logic REG_READ_ONLY     = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_DAT, ST_DONE} state_t;
  typedef enum logic [1:0] {MODE_GET, MODE_UE, MODE_PUT} mode_t;

endpackage

// ----- src/ebr_ram.sv -----
// generic single-port ram, registered read
// no dependencies
module ebr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/bitstream_reader_writer_exp_golomb_unit.sv -----
// msb-first bit cursor over a byte buffer with exp-golomb decode and bit writes
// uses ebr_pkg and ebr_ram
//
// channel | ports                          | handshake
// input   | in_*                           | start && !busy
// result  | out_*                          | out_valid, one cycle
// config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// load, rewind, skip, align, unknown codes and refused writes or pads go from idle straight to done.
// read, peek, write, pad: a ram read state and a data state per buffer byte touched, then done.
// ue/se: a read state and a data state per byte of leading zeros, then the suffix as a read.
// the single ram port lets the unit fetch only one buffer byte at a time.
// reset clears the cursor and config; buffer contents stay undefined.
// the receiver cannot stall; a result shows for one cycle.
module bitstream_reader_writer_exp_golomb_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          in_cmd,
  input  logic [5:0]          in_bit_count,
  input  logic [15:0]         in_skip_bits,
  input  logic [31:0]         in_write_bits,
  input  logic [11:0]         in_load_address,
  input  logic [7:0]          in_load_data,
  output logic                out_valid,
  output logic [31:0]         out_value,
  output logic signed [31:0]  out_signed_value,
  output logic [15:0]         out_bit_position,
  output logic [15:0]         out_bits_remaining,
  output logic                out_at_end,
  output logic                out_is_aligned,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [12:0]         cfg_wdata
);

  localparam int CW = ebr_pkg::CUR_W;

  ebr_pkg::state_t state_r, state_nxt;
  ebr_pkg::mode_t  mode_r, mode_nxt;
  logic [3:0]    cmd_r, cmd_nxt;
  logic [5:0]    n_r, n_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [31:0]   wbits_r, wbits_nxt;
  logic [4:0]    zeros_r, zeros_nxt;
  logic          ue_r, ue_nxt;
  logic [CW-1:0] cur_r, cur_nxt, scur_r, scur_nxt;
  logic [3:0]    bl_r, bl_nxt, sbl_r, sbl_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [12:0]   slen_r;
  logic          ro_r;
  logic          out_valid_r;
  logic [31:0]   out_value_r, out_svalue_r;
  logic [15:0]   out_pos_r, out_rem_r;
  logic          out_end_r, out_al_r;

  logic                        ram_we;
  logic [ebr_pkg::ADDR_W-1:0]  ram_addr;
  logic [7:0]                  ram_wdata, ram_rdata;

  logic [CW-1:0] end_byte;
  logic          have;

  assign end_byte = (slen_r < CW'(ebr_pkg::BUF_BYTES)) ? slen_r : CW'(ebr_pkg::BUF_BYTES);
  assign have     = cur_r < end_byte;

  ebr_ram #(.WIDTH(8), .DEPTH(ebr_pkg::BUF_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ebr_pkg::ST_IDLE;
      cur_r       <= '0;
      bl_r        <= 4'd8;
      slen_r      <= '0;
      ro_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      bl_r        <= bl_nxt;
      out_valid_r <= (state_r == ebr_pkg::ST_DONE);
      if (cfg_we) begin
        case (cfg_index)
          ebr_pkg::REG_STREAM_LENGTH: slen_r <= cfg_wdata;
          ebr_pkg::REG_READ_ONLY:     ro_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    cmd_r   <= cmd_nxt;
    n_r     <= n_nxt;
    acc_r   <= acc_nxt;
    wbits_r <= wbits_nxt;
    zeros_r <= zeros_nxt;
    ue_r    <= ue_nxt;
    scur_r  <= scur_nxt;
    sbl_r   <= sbl_nxt;
    val_r   <= val_nxt;
  end

  // result word, computed in the done state
  logic [CW-1:0] diff;
  assign diff = end_byte - cur_r;

  always_ff @(posedge clk) begin
    if (state_r == ebr_pkg::ST_DONE) begin
      out_value_r  <= val_r;
      if (cmd_r == ebr_pkg::CMD_SE) begin
        out_svalue_r <= val_r[0] ? ({1'b0, val_r[31:1]} + 32'd1) : (32'd0 - {1'b0, val_r[31:1]});
      end else begin
        out_svalue_r <= '0;
      end
      out_pos_r <= {cur_r[12:0], 3'b000} + 16'd8 - {12'd0, bl_r};
      out_rem_r <= have ? ({diff, 3'b000} - 16'd8 + {12'd0, bl_r}) : 16'd0;
      out_end_r <= !have;
      out_al_r  <= (bl_r == 4'd8);
    end
  end

  assign busy               = (state_r != ebr_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_signed_value   = out_svalue_r;
  assign out_bit_position   = out_pos_r;
  assign out_bits_remaining = out_rem_r;
  assign out_at_end         = out_end_r;
  assign out_is_aligned     = out_al_r;

  always_comb begin
    logic [16:0] pos, target;
    logic [5:0]  ncl;
    logic [3:0]  k, l, cons, sh;
    logic [7:0]  kmask, bits, m;
    logic [4:0]  z;
    logic        stop, bitv, lastb;
    logic [2:0]  idx;
    logic [31:0] shifted, ones;

    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd_nxt   = cmd_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    wbits_nxt = wbits_r;
    zeros_nxt = zeros_r;
    ue_nxt    = ue_r;
    cur_nxt   = cur_r;
    bl_nxt    = bl_r;
    scur_nxt  = scur_r;
    sbl_nxt   = sbl_r;
    val_nxt   = val_r;
    ram_we    = 1'b0;
    ram_addr  = cur_r[ebr_pkg::ADDR_W-1:0];
    ram_wdata = '0;

    pos = {1'b0, cur_r, 3'b000} + 17'd8 - {13'd0, bl_r};
    target = pos + {1'b0, in_skip_bits};
    ncl = (in_bit_count > ebr_pkg::MAX_BITS) ? ebr_pkg::MAX_BITS : in_bit_count;
    k = ({2'b00, bl_r} < n_r) ? bl_r : n_r[3:0];
    sh = bl_r - k;
    kmask = 8'((9'd1 << k) - 9'd1);
    bits = 8'd0;
    m = 8'd0;
    z = zeros_r;
    stop = 1'b0;
    l = bl_r;
    cons = 4'd0;
    bitv = 1'b0;
    idx = 3'd0;
    lastb = 1'b0;
    shifted = acc_r << n_r;
    ones = (32'd1 << zeros_r) - 32'd1;

    case (state_r)
      ebr_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          val_nxt   = '0;
          acc_nxt   = '0;
          zeros_nxt = '0;
          ue_nxt    = 1'b0;
          scur_nxt  = cur_r;
          sbl_nxt   = bl_r;
          wbits_nxt = in_write_bits;
          n_nxt     = ncl;
          state_nxt = ebr_pkg::ST_DONE;
          case (in_cmd)
            ebr_pkg::CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_addr  = in_load_address;
              ram_wdata = in_load_data;
            end
            ebr_pkg::CMD_REWIND: begin
              cur_nxt = '0;
              bl_nxt  = 4'd8;
            end
            ebr_pkg::CMD_SKIP: begin
              if (have) begin
                if (target >= {1'b0, end_byte, 3'b000}) begin
                  cur_nxt = end_byte;
                  bl_nxt  = 4'd8;
                end else begin
                  cur_nxt = target[15:3];
                  bl_nxt  = 4'd8 - {1'b0, target[2:0]};
                end
              end
            end
            ebr_pkg::CMD_ALIGN: begin
              if (bl_r != 4'd8) begin
                bl_nxt = 4'd8;
                if (cur_r < ebr_pkg::CURSOR_MAX) begin
                  cur_nxt = cur_r + CW'(1);
                end
              end
            end
            ebr_pkg::CMD_READ, ebr_pkg::CMD_PEEK: begin
              mode_nxt  = ebr_pkg::MODE_GET;
              state_nxt = ebr_pkg::ST_RD;
            end
            ebr_pkg::CMD_UE, ebr_pkg::CMD_SE: begin
              mode_nxt  = ebr_pkg::MODE_UE;
              state_nxt = ebr_pkg::ST_RD;
            end
            ebr_pkg::CMD_WRITE: begin
              if (!ro_r) begin
                mode_nxt  = ebr_pkg::MODE_PUT;
                state_nxt = ebr_pkg::ST_RD;
              end
            end
            ebr_pkg::CMD_PAD0, ebr_pkg::CMD_PAD1: begin
              if (!ro_r && bl_r != 4'd8) begin
                mode_nxt  = ebr_pkg::MODE_PUT;
                n_nxt     = {2'b00, bl_r};
                wbits_nxt = (in_cmd == ebr_pkg::CMD_PAD1) ? 32'hFFFF_FFFF : 32'd0;
                state_nxt = ebr_pkg::ST_RD;
              end
            end
            default: ;
          endcase
        end
      end

      ebr_pkg::ST_RD: begin
        // ram read at cursor issued here unless the operation is over
        state_nxt = ebr_pkg::ST_DAT;
        case (mode_r)
          ebr_pkg::MODE_GET: begin
            if (n_r == 6'd0 || !have) begin
              state_nxt = ebr_pkg::ST_DONE;
              val_nxt   = ue_r ? (ones + shifted) : shifted;
              if (cmd_r == ebr_pkg::CMD_PEEK) begin
                cur_nxt = scur_r;
                bl_nxt  = sbl_r;
              end
            end
          end
          ebr_pkg::MODE_UE: begin
            if (!have) begin
              mode_nxt  = ebr_pkg::MODE_GET;
              ue_nxt    = 1'b1;
              n_nxt     = {1'b0, zeros_r};
              state_nxt = ebr_pkg::ST_RD;
            end
          end
          ebr_pkg::MODE_PUT: begin
            if (n_r == 6'd0 || !have) begin
              state_nxt = ebr_pkg::ST_DONE;
            end
          end
          default: state_nxt = ebr_pkg::ST_DONE;
        endcase
      end

      ebr_pkg::ST_DAT: begin
        state_nxt = ebr_pkg::ST_RD;
        case (mode_r)
          ebr_pkg::MODE_GET: begin
            bits    = (ram_rdata >> sh) & kmask;
            acc_nxt = (acc_r << k) | {24'd0, bits};
            n_nxt   = n_r - {2'b00, k};
            if (sh == 4'd0) begin
              cur_nxt = cur_r + CW'(1);
              bl_nxt  = 4'd8;
            end else begin
              bl_nxt = sh;
            end
          end
          ebr_pkg::MODE_UE: begin
            // scan this byte for the terminating one bit, the last bit of the stream or the zero limit
            for (int j = 0; j < 8; j++) begin
              if (!stop && 4'(j) < l) begin
                idx   = 3'(l - 4'd1 - 4'(j));
                bitv  = ram_rdata[idx];
                cons  = cons + 4'd1;
                lastb = (4'(j) == l - 4'd1) && ((cur_r + CW'(1)) >= end_byte);
                if (bitv || lastb || z >= ebr_pkg::MAX_ZEROS) begin
                  stop = 1'b1;
                end else begin
                  z = z + 5'd1;
                end
              end
            end
            zeros_nxt = z;
            if (l - cons == 4'd0) begin
              cur_nxt = cur_r + CW'(1);
              bl_nxt  = 4'd8;
            end else begin
              bl_nxt = l - cons;
            end
            if (stop) begin
              mode_nxt = ebr_pkg::MODE_GET;
              ue_nxt   = 1'b1;
              n_nxt    = {1'b0, z};
            end
          end
          ebr_pkg::MODE_PUT: begin
            bits      = 8'((wbits_r >> (n_r - {2'b00, k}))) & kmask;
            m         = kmask << sh;
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata & ~m) | ((bits << sh) & m);
            n_nxt     = n_r - {2'b00, k};
            if (sh == 4'd0) begin
              cur_nxt = cur_r + CW'(1);
              bl_nxt  = 4'd8;
            end else begin
              bl_nxt = sh;
            end
          end
          default: state_nxt = ebr_pkg::ST_DONE;
        endcase
      end

      ebr_pkg::ST_DONE: begin
        state_nxt = ebr_pkg::ST_IDLE;
      end

      default: state_nxt = ebr_pkg::ST_IDLE;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not make the unit busy");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe outside idle or longer than one cycle");

  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    bl_r != 4'd0 && bl_r <= 4'd8)
    else $error("bits left in byte out of range");

endmodule
